/* rtl/va_pkg.sv */
// va_pkg: shared types and constants for the three-component vector unit
// holds beat structs, mode and operation codes, and back-end states; no dependencies
package va_pkg;

  localparam int unsigned COMP_W   = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SCALAR_W = 48;
  localparam int unsigned QUEUE_D  = 2;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_CROSS = 4'd2,
    MODE_NORM  = 4'd3,
    MODE_NEG   = 4'd4,
    MODE_MAG   = 4'd5,
    MODE_MAG2  = 4'd6,
    MODE_DIST2 = 4'd7,
    MODE_DIST  = 4'd8
  } mode_e;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_CROSS,
    OP_NORM,
    OP_MAG,
    OP_MAG2,
    OP_DIST2,
    OP_DIST,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQ,
    BK_XP,
    BK_NM,
    BK_SQRT,
    BK_DIV,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [COMP_W-1:0] ax;
    logic signed [COMP_W-1:0] ay;
    logic signed [COMP_W-1:0] az;
    logic signed [COMP_W-1:0] bx;
    logic signed [COMP_W-1:0] by_comp;
    logic signed [COMP_W-1:0] bz;
  } in_beat_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] rx;
    logic signed [COMP_W-1:0] ry;
    logic signed [COMP_W-1:0] rz;
    logic [SCALAR_W-1:0]      scalar_out;
    logic                     overflow;
    logic                     zero_norm;
  } out_beat_t;

  typedef struct packed {
    op_e                    op;
    logic [2:0][COMP_W-1:0] a;
    logic [2:0][COMP_W-1:0] b;
  } job_t;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       sub;
    logic       fin;
    logic       last;
    logic [1:0] idx;
  } mul_tag_t;

endpackage

/* rtl/va_front.sv */
// va_front: accepts input beats, decodes the mode into an operation class
// and holds jobs in a two-entry queue for the back end; uses va_pkg
module va_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  va_pkg::in_beat_t   in_beat_i,
  output logic               job_valid_o,
  output va_pkg::job_t       job_o,
  input  logic               job_pop_i
);

  localparam int unsigned PTR_W = $clog2(va_pkg::QUEUE_D);
  localparam int unsigned CNT_W = $clog2(va_pkg::QUEUE_D + 1);

  va_pkg::job_t            mem_q [va_pkg::QUEUE_D];
  logic [PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    push;
  logic                    pop;
  va_pkg::job_t            new_job;

  function automatic va_pkg::op_e decode(input logic [3:0] mode);
    va_pkg::op_e op;
    case (va_pkg::mode_e'(mode))
      va_pkg::MODE_ADD:   op = va_pkg::OP_ADD;
      va_pkg::MODE_SUB:   op = va_pkg::OP_SUB;
      va_pkg::MODE_CROSS: op = va_pkg::OP_CROSS;
      va_pkg::MODE_NORM:  op = va_pkg::OP_NORM;
      va_pkg::MODE_NEG:   op = va_pkg::OP_NEG;
      va_pkg::MODE_MAG:   op = va_pkg::OP_MAG;
      va_pkg::MODE_MAG2:  op = va_pkg::OP_MAG2;
      va_pkg::MODE_DIST2: op = va_pkg::OP_DIST2;
      va_pkg::MODE_DIST:  op = va_pkg::OP_DIST;
      default:            op = va_pkg::OP_NONE;
    endcase
    return op;
  endfunction

  assign in_stall_o  = (cnt_q == CNT_W'(va_pkg::QUEUE_D));
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && job_valid_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_ptr_q];

  always_comb begin
    new_job.op   = decode(in_beat_i.mode);
    new_job.a[0] = in_beat_i.ax;
    new_job.a[1] = in_beat_i.ay;
    new_job.a[2] = in_beat_i.az;
    new_job.b[0] = in_beat_i.bx;
    new_job.b[1] = in_beat_i.by_comp;
    new_job.b[2] = in_beat_i.bz;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_job;
    end
  end

endmodule

/* rtl/va_back.sv */
// va_back: carries out queued jobs with one shared multiplier, a bit-serial
// square root and a bit-serial reciprocal; owns the output register; uses va_pkg
module va_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  va_pkg::job_t      job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output va_pkg::out_beat_t out_beat_o
);

  localparam int unsigned W    = va_pkg::COMP_W;
  localparam int unsigned F    = va_pkg::FRAC_W;
  localparam int unsigned SCW  = va_pkg::SCALAR_W;
  localparam int unsigned QW   = 2 * F + 1;
  localparam int unsigned OW   = (W + 1 > QW + 1) ? W + 1 : QW + 1;
  localparam int unsigned PW   = 2 * OW;
  localparam int unsigned AW   = PW + 1;
  localparam int unsigned RTW  = W + 1;
  localparam int unsigned RW   = 2 * RTW;
  localparam int unsigned RMW  = RTW + 2;
  localparam int unsigned DRW  = RTW + 1;
  localparam int unsigned MAXN = (RTW > QW) ? RTW : QW;
  localparam int unsigned CNTW = $clog2(MAXN + 1);
  localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);

  va_pkg::bk_state_e        st_q, st_d;
  logic [CNTW-1:0]          cnt_q, cnt_d;
  va_pkg::op_e              op_q, op_d;
  logic [2:0][W-1:0]        a_q, a_d;
  logic [2:0][W-1:0]        b_q, b_d;
  logic signed [AW-1:0]     acc_q, acc_d;
  logic signed [PW-1:0]     prod_q, prod_d;
  va_pkg::mul_tag_t         tag_q, tag_d;
  logic [RW-1:0]            rad_q, rad_d;
  logic [RMW-1:0]           rem_q, rem_d;
  logic [RTW-1:0]           root_q, root_d;
  logic [DRW-1:0]           drem_q, drem_d;
  logic [QW-1:0]            quo_q, quo_d;
  logic [2:0][W-1:0]        r_q, r_d;
  logic [SCW-1:0]           sc_q, sc_d;
  logic                     ovf_q, ovf_d;
  logic                     zn_q, zn_d;
  logic                     ov_q, ov_d;
  va_pkg::out_beat_t        out_q, out_d;

  logic                     out_free;
  logic signed [OW-1:0]     x_op, y_op;
  logic [2:0][OW-1:0]       sq_v;
  logic                     use_d;
  logic signed [AW-1:0]     pe, acc_base, acc_new;
  logic [W:0]               tc;
  logic [AW-1:0]            srnd;
  logic [RMW-1:0]           rem_sh, trial;
  logic [RTW-1:0]           root_nx;
  logic [DRW-1:0]           dsh;
  va_pkg::out_beat_t        simple_res;
  logic [W:0]               ssum;
  logic signed [W:0]        ea, eb;

  // rounds a 2F-fraction value to a saturated component, msb is the overflow flag
  function automatic logic [W:0] to_comp(input logic signed [AW-1:0] v);
    logic          neg;
    logic [AW-1:0] mag, rnd, lim, q;
    logic          ovf;
    neg = v[AW-1];
    mag = neg ? AW'(-v) : AW'(v);
    rnd = (mag + HALF) >> F;
    lim = (AW'(1) << (W - 1)) - (neg ? AW'(0) : AW'(1));
    ovf = (rnd > lim);
    q   = ovf ? lim : rnd;
    q   = neg ? AW'(-q) : q;
    return {ovf, q[W-1:0]};
  endfunction

  assign out_free    = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign out_beat_o  = out_q;

  // add, subtract and negate, computed combinationally from the queue head
  always_comb begin
    simple_res = '0;
    ea   = '0;
    eb   = '0;
    ssum = '0;
    for (int i = 0; i < 3; i++) begin
      ea = {job_i.a[i][W-1], job_i.a[i]};
      eb = {job_i.b[i][W-1], job_i.b[i]};
      case (job_i.op)
        va_pkg::OP_ADD: ssum = (W+1)'(ea + eb);
        va_pkg::OP_SUB: ssum = (W+1)'(ea - eb);
        va_pkg::OP_NEG: ssum = (W+1)'(-ea);
        default:        ssum = '0;
      endcase
      if (ssum[W] != ssum[W-1]) begin
        simple_res.overflow = 1'b1;
        ssum[W-1:0] = ssum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      case (i)
        0:       simple_res.rx = ssum[W-1:0];
        1:       simple_res.ry = ssum[W-1:0];
        default: simple_res.rz = ssum[W-1:0];
      endcase
    end
  end

  // multiplier operand issue
  always_comb begin
    x_op  = '0;
    y_op  = '0;
    tag_d = '0;
    use_d = op_q inside {va_pkg::OP_DIST2, va_pkg::OP_DIST};
    for (int i = 0; i < 3; i++) begin
      if (use_d) begin
        sq_v[i] = OW'($signed({a_q[i][W-1], a_q[i]}) - $signed({b_q[i][W-1], b_q[i]}));
      end else begin
        sq_v[i] = OW'($signed(a_q[i]));
      end
    end
    case (st_q)
      va_pkg::BK_SQ: begin
        if (cnt_q < CNTW'(3)) begin
          x_op        = $signed(sq_v[cnt_q[1:0]]);
          y_op        = x_op;
          tag_d.vld   = 1'b1;
          tag_d.first = (cnt_q == '0);
          tag_d.fin   = (cnt_q == CNTW'(2));
          tag_d.last  = (cnt_q == CNTW'(2));
        end
      end
      va_pkg::BK_XP: begin
        if (cnt_q < CNTW'(6)) begin
          tag_d.vld   = 1'b1;
          tag_d.first = !cnt_q[0];
          tag_d.sub   = cnt_q[0];
          tag_d.fin   = cnt_q[0];
          tag_d.last  = (cnt_q == CNTW'(5));
          case (cnt_q[2:0])
            3'd0: begin x_op = OW'($signed(a_q[1])); y_op = OW'($signed(b_q[2])); end
            3'd1: begin x_op = OW'($signed(a_q[2])); y_op = OW'($signed(b_q[1])); end
            3'd2: begin x_op = OW'($signed(a_q[2])); y_op = OW'($signed(b_q[0])); end
            3'd3: begin x_op = OW'($signed(a_q[0])); y_op = OW'($signed(b_q[2])); end
            3'd4: begin x_op = OW'($signed(a_q[0])); y_op = OW'($signed(b_q[1])); end
            default: begin x_op = OW'($signed(a_q[1])); y_op = OW'($signed(b_q[0])); end
          endcase
          tag_d.idx = 2'(cnt_q[2:1]);
        end
      end
      va_pkg::BK_NM: begin
        if (cnt_q < CNTW'(3)) begin
          x_op        = OW'($signed(a_q[cnt_q[1:0]]));
          y_op        = $signed(OW'(quo_q));
          tag_d.vld   = 1'b1;
          tag_d.first = 1'b1;
          tag_d.fin   = 1'b1;
          tag_d.idx   = cnt_q[1:0];
          tag_d.last  = (cnt_q == CNTW'(2));
        end
      end
      default: ;
    endcase
    prod_d = x_op * y_op;
  end

  // accumulate, iterate and sequence
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    drem_d = drem_q;
    quo_d  = quo_q;
    r_d    = r_q;
    sc_d   = sc_q;
    ovf_d  = ovf_q;
    zn_d   = zn_q;
    ov_d   = ov_q && out_stall_i;
    out_d  = out_q;
    job_pop_o = 1'b0;

    pe       = AW'(prod_q);
    acc_base = tag_q.first ? '0 : acc_q;
    acc_new  = tag_q.sub ? acc_base - pe : acc_base + pe;
    tc       = to_comp(acc_new);
    srnd     = (AW'(acc_new) + HALF) >> F;

    rem_sh  = {rem_q[RMW-3:0], rad_q[RW-1:RW-2]};
    trial   = {root_q, 2'b01};
    root_nx = {root_q[RTW-2:0], (rem_sh >= trial)};
    dsh     = {drem_q[DRW-2:0], (cnt_q == '0)};

    if (tag_d.vld) begin
      cnt_d = cnt_q + CNTW'(1);
    end

    if (tag_q.vld) begin
      acc_d = acc_new;
      if (tag_q.fin && (st_q != va_pkg::BK_SQ)) begin
        r_d[tag_q.idx] = tc[W-1:0];
        ovf_d          = ovf_q | tc[W];
      end
      if (tag_q.last) begin
        cnt_d = '0;
        if (st_q == va_pkg::BK_SQ) begin
          if (op_q inside {va_pkg::OP_MAG2, va_pkg::OP_DIST2}) begin
            if (srnd > AW'({SCW{1'b1}})) begin
              sc_d  = {SCW{1'b1}};
              ovf_d = 1'b1;
            end else begin
              sc_d = srnd[SCW-1:0];
            end
            st_d = va_pkg::BK_DONE;
          end else if ((op_q == va_pkg::OP_NORM) && (acc_new == '0)) begin
            zn_d = 1'b1;
            st_d = va_pkg::BK_DONE;
          end else begin
            rad_d  = acc_new[RW-1:0];
            rem_d  = '0;
            root_d = '0;
            st_d   = va_pkg::BK_SQRT;
          end
        end else begin
          st_d = va_pkg::BK_DONE;
        end
      end
    end

    case (st_q)
      va_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.op inside {va_pkg::OP_ADD, va_pkg::OP_SUB, va_pkg::OP_NEG,
                               va_pkg::OP_NONE}) begin
            if (out_free) begin
              job_pop_o = 1'b1;
              ov_d      = 1'b1;
              out_d     = simple_res;
            end
          end else begin
            job_pop_o = 1'b1;
            op_d      = job_i.op;
            a_d       = job_i.a;
            b_d       = job_i.b;
            r_d       = '0;
            sc_d      = '0;
            ovf_d     = 1'b0;
            zn_d      = 1'b0;
            cnt_d     = '0;
            st_d      = (job_i.op == va_pkg::OP_CROSS) ? va_pkg::BK_XP : va_pkg::BK_SQ;
          end
        end
      end
      va_pkg::BK_SQRT: begin
        rem_d  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        root_d = root_nx;
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(RTW - 1)) begin
          cnt_d = '0;
          if (op_q == va_pkg::OP_NORM) begin
            drem_d = '0;
            quo_d  = '0;
            st_d   = va_pkg::BK_DIV;
          end else begin
            sc_d = SCW'(root_nx);
            st_d = va_pkg::BK_DONE;
          end
        end
      end
      va_pkg::BK_DIV: begin
        // restoring divide of one at 2F fraction bits by the root
        if (dsh >= DRW'(root_q)) begin
          drem_d = dsh - DRW'(root_q);
          quo_d  = {quo_q[QW-2:0], 1'b1};
        end else begin
          drem_d = dsh;
          quo_d  = {quo_q[QW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(QW - 1)) begin
          cnt_d = '0;
          st_d  = va_pkg::BK_NM;
        end
      end
      va_pkg::BK_DONE: begin
        if (out_free) begin
          ov_d                 = 1'b1;
          out_d.rx             = r_q[0];
          out_d.ry             = r_q[1];
          out_d.rz             = r_q[2];
          out_d.scalar_out     = sc_q;
          out_d.overflow       = ovf_q;
          out_d.zero_norm      = zn_q;
          st_d                 = va_pkg::BK_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= va_pkg::BK_IDLE;
      cnt_q <= '0;
      tag_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      tag_q <= tag_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    drem_q <= drem_d;
    quo_q  <= quo_d;
    r_q    <= r_d;
    sc_q   <= sc_d;
    ovf_q  <= ovf_d;
    zn_q   <= zn_d;
    out_q  <= out_d;
  end

endmodule

/* rtl/vector3_alu.sv */
// Three-component vector unit on signed Q16.16 vectors: add, subtract and
// negate are computed combinationally and written to the result register once
// it is free; squared magnitude, squared distance, cross product, magnitude,
// distance and normalize run on the single shared 34x34 multiplier,
// the bit-serial square root (one root bit per cycle) and the bit-serial
// reciprocal (one quotient bit per cycle). A two-beat queue in front keeps
// accepting input until full while the back end works, and a result register
// lets the next operation start while a finished beat waits on the output.
// Depends on va_pkg, va_front and va_back.
module vector3_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  va_pkg::in_beat_t  in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output va_pkg::out_beat_t out_beat_o
);

  logic         job_valid;
  logic         job_pop;
  va_pkg::job_t job;

  va_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  va_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
